// ----- sv/pctd_pkg.sv -----
// shared types and constants for the prefix code tree decoder
// used by every module of the block; no dependencies of its own
`default_nettype none

package pctd_pkg;

	localparam int NODE_COUNT_DEF   = 512;
	localparam int MAX_CODE_LEN_DEF = 16;

	localparam int SYM_W    = 8;
	localparam int CODE_W   = 16;
	localparam int LENIN_W  = 5;
	localparam int LEN_W    = 6;   // holds the saturated length, at most 31
	localparam int STATUS_W = 2;

	localparam int QUEUE_DEPTH = 2;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_DECODE = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_BAD_PATH = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;

	// classified item handed from front to back
	typedef struct packed {
		logic              is_decode;
		logic              stream_bit;
		logic [SYM_W-1:0]  sym;
		logic [CODE_W-1:0] code;
		logic [LEN_W-1:0]  len;
	} item_t;

endpackage

`default_nettype wire

// ----- sv/pctd_front.sv -----
// front end: takes items from the input queue interface, classifies them
// and saturates the code length; depends on pctd_pkg
`default_nettype none

module pctd_front #(
	parameter int MAX_CODE_LEN = pctd_pkg::MAX_CODE_LEN_DEF
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        in_take,
	input  wire                        opcode,
	input  wire [pctd_pkg::SYM_W-1:0]  symbol_byte,
	input  wire [pctd_pkg::CODE_W-1:0] code_bits,
	input  wire [pctd_pkg::LENIN_W-1:0] code_length,
	input  wire                        stream_bit,
	output logic                       ready,
	input  wire                        q_full,
	output logic                       q_push,
	output pctd_pkg::item_t            q_item
);
	import pctd_pkg::*;

	logic  valid_s1;
	item_t item_s1;
	item_t cls;

	always_comb begin
		cls.is_decode  = (opcode == OP_DECODE);
		cls.stream_bit = stream_bit;
		cls.sym        = symbol_byte;
		cls.code       = code_bits;
		// lengths past the maximum are clamped
		if (32'(code_length) > MAX_CODE_LEN)
			cls.len = LEN_W'(MAX_CODE_LEN);
		else
			cls.len = LEN_W'(code_length);
	end

	assign q_push = valid_s1 && !q_full;
	assign ready  = !valid_s1 || !q_full;
	assign q_item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (q_push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1 <= cls;
		end
	end

endmodule

`default_nettype wire

// ----- sv/pctd_queue.sv -----
// short item queue that decouples the front end from the tree engine
// depends on pctd_pkg for the item type
`default_nettype none

module pctd_queue (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             push,
	input  pctd_pkg::item_t wr_item,
	output logic            full,
	input  wire             pop,
	output logic            valid,
	output pctd_pkg::item_t rd_item
);
	import pctd_pkg::*;

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	item_t          slot_q [QUEUE_DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;

	assign full    = (count_q == CW'(QUEUE_DEPTH));
	assign valid   = (count_q != '0);
	assign rd_item = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_item;
		end
	end

endmodule

`default_nettype wire

// ----- sv/pctd_back.sv -----
// tree engine: node tables, insert walk, decode steps and result register
// depends on pctd_pkg; clears the child tables once after reset
`default_nettype none

module pctd_back #(
	parameter int NODE_COUNT = pctd_pkg::NODE_COUNT_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          q_valid,
	input  pctd_pkg::item_t              q_item,
	output logic                         q_pop,
	output logic                         clearing,
	output logic                         empty,
	input  wire                          pop,
	output logic [pctd_pkg::STATUS_W-1:0] status,
	output logic [pctd_pkg::SYM_W-1:0]   decoded_symbol
);
	import pctd_pkg::*;

	localparam int NW = $clog2(NODE_COUNT);
	localparam int FW = $clog2(NODE_COUNT + 1);

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_DEC1  = 3'd2;
	localparam logic [2:0] S_DEC2  = 3'd3;
	localparam logic [2:0] S_WALK  = 3'd4;

	logic [NW-1:0]    left_mem  [NODE_COUNT];
	logic [NW-1:0]    right_mem [NODE_COUNT];
	logic [SYM_W-1:0] sym_mem   [NODE_COUNT];

	logic [2:0]       st_q, st_d;
	logic [NW-1:0]    clr_q, clr_d;
	logic [NW-1:0]    cur_q, cur_d;
	logic [NW-1:0]    node_q, node_d;
	logic [FW-1:0]    free_q, free_d;
	logic [LEN_W-1:0] cnt_q, cnt_d;
	logic             fresh_q, fresh_d;
	item_t            item_q;

	logic             rd_en;
	logic [NW-1:0]    rd_addr;
	logic [NW-1:0]    rdl_q, rdr_q;
	logic             sym_rd_en;
	logic [SYM_W-1:0] sym_rd_q;
	logic             l_we, r_we;
	logic [NW-1:0]    w_addr, w_data;
	logic             sym_we;
	logic [NW-1:0]    sym_waddr;
	logic [SYM_W-1:0] sym_wdata;

	logic                res_v_q;
	logic [STATUS_W-1:0] res_status_q;
	logic [SYM_W-1:0]    res_sym_q;
	logic                res_load;
	logic [STATUS_W-1:0] res_status_d;
	logic [SYM_W-1:0]    res_sym_d;
	logic                out_free;

	logic [LEN_W-1:0] pos;
	logic             walk_bit;
	logic [NW-1:0]    walk_slot;
	logic [NW-1:0]    dec_child;

	assign out_free = !res_v_q || pop;
	assign empty    = !res_v_q;
	assign status   = res_status_q;
	assign decoded_symbol = res_sym_q;
	assign clearing = (st_q == S_CLEAR);

	// code bits above the 16-bit field read as zero
	assign pos       = cnt_q - 1'b1;
	assign walk_bit  = (32'(pos) < CODE_W) && item_q.code[4'(pos)];
	assign walk_slot = fresh_q ? '0 : (walk_bit ? rdr_q : rdl_q);
	assign dec_child = item_q.stream_bit ? rdr_q : rdl_q;

	always_comb begin
		st_d      = st_q;
		clr_d     = clr_q;
		cur_d     = cur_q;
		node_d    = node_q;
		free_d    = free_q;
		cnt_d     = cnt_q;
		fresh_d   = fresh_q;
		q_pop     = 1'b0;
		rd_en     = 1'b0;
		rd_addr   = '0;
		sym_rd_en = 1'b0;
		l_we      = 1'b0;
		r_we      = 1'b0;
		w_addr    = '0;
		w_data    = '0;
		sym_we    = 1'b0;
		sym_waddr = '0;
		sym_wdata = item_q.sym;
		res_load  = 1'b0;
		res_status_d = ST_OK;
		res_sym_d    = '0;
		unique case (st_q)
			S_CLEAR: begin
				l_we   = 1'b1;
				r_we   = 1'b1;
				w_addr = clr_q;
				clr_d  = clr_q + 1'b1;
				if (clr_q == NW'(NODE_COUNT - 1)) begin
					st_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (q_valid) begin
					q_pop   = 1'b1;
					rd_en   = 1'b1;
					node_d  = '0;
					fresh_d = 1'b0;
					cnt_d   = q_item.len;
					if (q_item.is_decode) begin
						rd_addr = cur_q;
						st_d    = S_DEC1;
					end else if (q_item.len == '0) begin
						// empty code names the root itself
						sym_we    = 1'b1;
						sym_waddr = '0;
						sym_wdata = q_item.sym;
					end else begin
						rd_addr = '0;
						st_d    = S_WALK;
					end
				end
			end
			S_WALK: begin
				if (walk_slot != '0) begin
					node_d = walk_slot;
					cnt_d  = cnt_q - 1'b1;
					if (cnt_q == LEN_W'(1)) begin
						sym_we    = 1'b1;
						sym_waddr = walk_slot;
						st_d      = S_IDLE;
					end else begin
						rd_en   = 1'b1;
						rd_addr = walk_slot;
					end
				end else if (free_q >= FW'(NODE_COUNT)) begin
					if (out_free) begin
						res_load     = 1'b1;
						res_status_d = ST_FULL;
						st_d         = S_IDLE;
					end
				end else begin
					// a fresh node has no children, so later steps need no read
					l_we    = !walk_bit;
					r_we    = walk_bit;
					w_addr  = node_q;
					w_data  = NW'(free_q);
					node_d  = NW'(free_q);
					free_d  = free_q + 1'b1;
					fresh_d = 1'b1;
					cnt_d   = cnt_q - 1'b1;
					if (cnt_q == LEN_W'(1)) begin
						sym_we    = 1'b1;
						sym_waddr = NW'(free_q);
						st_d      = S_IDLE;
					end
				end
			end
			S_DEC1: begin
				if (dec_child == '0) begin
					if (out_free) begin
						res_load     = 1'b1;
						res_status_d = ST_BAD_PATH;
						cur_d        = '0;
						st_d         = S_IDLE;
					end
				end else begin
					rd_en     = 1'b1;
					rd_addr   = dec_child;
					sym_rd_en = 1'b1;
					node_d    = dec_child;
					st_d      = S_DEC2;
				end
			end
			S_DEC2: begin
				if (rdl_q == '0 && rdr_q == '0) begin
					if (out_free) begin
						res_load     = 1'b1;
						res_status_d = ST_OK;
						res_sym_d    = sym_rd_q;
						cur_d        = '0;
						st_d         = S_IDLE;
					end
				end else begin
					cur_d = node_q;
					st_d  = S_IDLE;
				end
			end
			default: begin
				st_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= S_CLEAR;
			clr_q   <= '0;
			cur_q   <= '0;
			node_q  <= '0;
			free_q  <= FW'(1);
			cnt_q   <= '0;
			fresh_q <= 1'b0;
			res_v_q <= 1'b0;
		end else begin
			st_q    <= st_d;
			clr_q   <= clr_d;
			cur_q   <= cur_d;
			node_q  <= node_d;
			free_q  <= free_d;
			cnt_q   <= cnt_d;
			fresh_q <= fresh_d;
			if (res_load) begin
				res_v_q <= 1'b1;
			end else if (pop) begin
				res_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			item_q <= q_item;
		end
		if (res_load) begin
			res_status_q <= res_status_d;
			res_sym_q    <= res_sym_d;
		end
	end

	// child tables
	always_ff @(posedge clk) begin
		if (l_we) begin
			left_mem[w_addr] <= w_data;
		end
		if (r_we) begin
			right_mem[w_addr] <= w_data;
		end
		if (rd_en) begin
			rdl_q <= left_mem[rd_addr];
			rdr_q <= right_mem[rd_addr];
		end
	end

	// symbol table
	always_ff @(posedge clk) begin
		if (sym_we) begin
			sym_mem[sym_waddr] <= sym_wdata;
		end
		if (sym_rd_en) begin
			sym_rd_q <= sym_mem[rd_addr];
		end
	end

	a_free_bound: assert property (@(posedge clk) disable iff (!arst_n)
		free_q <= FW'(NODE_COUNT) && free_q != '0)
		else $error("free node counter out of range");

	a_cur_allocated: assert property (@(posedge clk) disable iff (!arst_n)
		FW'(cur_q) < free_q)
		else $error("current node not allocated");

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> st_q == S_IDLE)
		else $error("item taken while engine busy");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |-> (st_q == S_DEC1 || st_q == S_DEC2 || st_q == S_WALK) && out_free)
		else $error("result loaded from wrong state or over a waiting result");

endmodule

`default_nettype wire

// ----- sv/prefix_code_tree_decoder_core.sv -----
// an accepted item passes through the front register and the queue before the engine takes it;
// a decode item reads the children of the current node, checked in S_DEC1, and if that child
// exists its children, checked in S_DEC2 (two dependent table reads); one read if no child
// an insert is taken in S_IDLE, then walks one code bit per S_WALK step, up to MAX_CODE_LEN
// the engine finishes each item before it takes the next; a result waits while one is unread
// after reset, full stays high while the child tables clear
`default_nettype none

module prefix_code_tree_decoder_core #(
	parameter int NODE_COUNT   = pctd_pkg::NODE_COUNT_DEF,
	parameter int MAX_CODE_LEN = pctd_pkg::MAX_CODE_LEN_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          push,
	output logic                         full,
	input  wire                          opcode,
	input  wire [pctd_pkg::SYM_W-1:0]    symbol_byte,
	input  wire [pctd_pkg::CODE_W-1:0]   code_bits,
	input  wire [pctd_pkg::LENIN_W-1:0]  code_length,
	input  wire                          stream_bit,
	output logic                         empty,
	input  wire                          pop,
	output logic [pctd_pkg::STATUS_W-1:0] status,
	output logic [pctd_pkg::SYM_W-1:0]   decoded_symbol
);
	import pctd_pkg::*;

	logic  front_ready;
	logic  clearing;
	logic  in_take;
	logic  q_push, q_full, q_pop, q_valid;
	item_t q_wr_item, q_rd_item;
	logic  res_pop;

	assign full    = clearing || !front_ready;
	assign in_take = push && !full;
	assign res_pop = pop && !empty;

	pctd_front #(
		.MAX_CODE_LEN(MAX_CODE_LEN)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_take     (in_take),
		.opcode      (opcode),
		.symbol_byte (symbol_byte),
		.code_bits   (code_bits),
		.code_length (code_length),
		.stream_bit  (stream_bit),
		.ready       (front_ready),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_item      (q_wr_item)
	);

	pctd_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.wr_item (q_wr_item),
		.full    (q_full),
		.pop     (q_pop),
		.valid   (q_valid),
		.rd_item (q_rd_item)
	);

	pctd_back #(
		.NODE_COUNT(NODE_COUNT)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_valid        (q_valid),
		.q_item         (q_rd_item),
		.q_pop          (q_pop),
		.clearing       (clearing),
		.empty          (empty),
		.pop            (res_pop),
		.status         (status),
		.decoded_symbol (decoded_symbol)
	);

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// self-checking bench for prefix_code_tree_decoder_core: builds code trees, decodes streams
// and checks every result against a tree predictor kept in the bench; depends on pctd_pkg
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import pctd_pkg::*;

	localparam int NODES = NODE_COUNT_DEF;
	localparam int NODE_W = $clog2(NODES);
	localparam int MAX_LEN = MAX_CODE_LEN_DEF;
	localparam int HALF_PERIOD = 6;
	localparam int STALL_LIMIT = 3000;
	localparam int TAIL_CYCLES = 40;
	localparam int PART_A_ITEMS = 430;
	localparam int TOTAL_ITEMS = 850;

	typedef struct packed {
		logic                drain_first;
		logic                op;
		logic [SYM_W-1:0]    sym;
		logic [CODE_W-1:0]   code;
		logic [LENIN_W-1:0]  len;
		logic                sbit;
	} tree_item_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [SYM_W-1:0]    sym;
	} outcome_t;

	typedef struct packed {
		logic [CODE_W-1:0]  code;
		logic [LENIN_W-1:0] len;
	} code_rec_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic pop = 1'b0;
	logic opcode = 1'b0;
	logic [SYM_W-1:0] symbol_byte = '0;
	logic [CODE_W-1:0] code_bits = '0;
	logic [LENIN_W-1:0] code_length = '0;
	logic stream_bit = 1'b0;
	logic full;
	logic empty;
	logic [STATUS_W-1:0] status;
	logic [SYM_W-1:0] decoded_symbol;

	// tree copies: index 0 is run ahead while planning items, index 1 follows acceptance
	logic [NODE_W-1:0] left_of [2][NODES];
	logic [NODE_W-1:0] right_of [2][NODES];
	logic [SYM_W-1:0] sym_at [2][NODES];
	bit sym_set [2][NODES];
	logic [NODE_W:0] free_next [2];
	logic [NODE_W-1:0] walk_at [2];

	tree_item_t pending [$];
	outcome_t expected_q [$];
	code_rec_t known_codes [$];
	bit drain_next = 1'b0;
	int planned_results = 0;
	int planned_full = 0;

	int items_in = 0;
	int item_total = 0;
	int inserts_in = 0;
	int seen_sym = 0;
	int seen_bad = 0;
	int seen_full = 0;
	int errors = 0;
	int idle_cycles = 0;
	int tx_gap = 0;
	int rx_gap = 0;
	int rx_hold = 0;
	bit long_hold_done = 1'b0;
	logic no_gaps;

	assign no_gaps = (items_in + 100 >= item_total) || ((items_in / 64) % 3 == 2);

	prefix_code_tree_decoder_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.opcode(opcode),
		.symbol_byte(symbol_byte),
		.code_bits(code_bits),
		.code_length(code_length),
		.stream_bit(stream_bit),
		.empty(empty),
		.pop(pop),
		.status(status),
		.decoded_symbol(decoded_symbol)
	);

	always #HALF_PERIOD clk = ~clk;

	function automatic void tree_apply(input int m, input tree_item_t it, output bit has,
			output outcome_t res);
		int len;
		int i;
		logic [NODE_W-1:0] n;
		logic [NODE_W:0] nxt;
		bit dir;
		has = 1'b0;
		res = '0;
		if (it.op == OP_INSERT) begin
			len = (it.len > MAX_LEN) ? MAX_LEN : int'(it.len);
			n = '0;
			for (i = len; i > 0; i--) begin
				dir = (i - 1 < CODE_W) ? it.code[i-1] : 1'b0;
				nxt = dir ? {1'b0, right_of[m][n]} : {1'b0, left_of[m][n]};
				if (nxt == '0) begin
					// out of nodes: the walk stops, nodes taken so far stay
					if (free_next[m] >= NODES) begin
						has = 1'b1;
						res.status = ST_FULL;
						return;
					end
					nxt = free_next[m];
					if (dir) begin
						right_of[m][n] = nxt[NODE_W-1:0];
					end else begin
						left_of[m][n] = nxt[NODE_W-1:0];
					end
					free_next[m] = free_next[m] + 1'b1;
				end
				n = nxt[NODE_W-1:0];
			end
			sym_at[m][n] = it.sym;
			sym_set[m][n] = 1'b1;
		end else begin
			n = walk_at[m];
			n = it.sbit ? right_of[m][n] : left_of[m][n];
			if (n == '0) begin
				has = 1'b1;
				res.status = ST_BAD_PATH;
				walk_at[m] = '0;
			end else if (left_of[m][n] == '0 && right_of[m][n] == '0) begin
				has = 1'b1;
				res.status = ST_OK;
				res.sym = sym_at[m][n];
				walk_at[m] = '0;
			end else begin
				walk_at[m] = n;
			end
		end
	endfunction

	function automatic tree_item_t make_insert(input logic [SYM_W-1:0] s,
			input logic [CODE_W-1:0] code, input logic [LENIN_W-1:0] len);
		tree_item_t it;
		it.drain_first = 1'b0;
		it.op = OP_INSERT;
		it.sym = s;
		it.code = code;
		it.len = len;
		it.sbit = 1'($urandom_range(0, 1));
		return it;
	endfunction

	function automatic tree_item_t make_decode(input logic b);
		tree_item_t it;
		it.drain_first = 1'b0;
		it.op = OP_DECODE;
		it.sym = 8'($urandom);
		it.code = 16'($urandom);
		it.len = 5'($urandom);
		it.sbit = b;
		return it;
	endfunction

	task automatic queue_item(input tree_item_t it);
		bit has;
		outcome_t res;
		logic [NODE_W-1:0] nxt;
		code_rec_t rec;
		int len;
		if (it.op == OP_DECODE) begin
			nxt = it.sbit ? right_of[0][walk_at[0]] : left_of[0][walk_at[0]];
			// a leaf left by an abandoned insert has no symbol: take the other branch
			if (nxt != '0 && left_of[0][nxt] == '0 && right_of[0][nxt] == '0 &&
					!sym_set[0][nxt])
				it.sbit = ~it.sbit;
		end
		it.drain_first = drain_next;
		drain_next = 1'b0;
		tree_apply(0, it, has, res);
		len = (it.len > MAX_LEN) ? MAX_LEN : int'(it.len);
		if (has) begin
			planned_results++;
			if (res.status == ST_FULL)
				planned_full++;
		end else if (it.op == OP_INSERT && len > 0) begin
			rec.code = it.code;
			rec.len = 5'(len);
			known_codes.push_back(rec);
		end
		pending.push_back(it);
	endtask

	task automatic send_code(input code_rec_t c);
		int i;
		// finish a walk left half way so that the code starts from the root
		while (walk_at[0] != '0)
			queue_item(make_decode(1'($urandom_range(0, 1))));
		for (i = int'(c.len) - 1; i >= 0; i--) begin
			queue_item(make_decode(c.code[i]));
			if (walk_at[0] == '0)
				break;
		end
	endtask

	task automatic random_burst(input bit reuse);
		int pick;
		code_rec_t c;
		pick = $urandom_range(0, 99);
		c = '0;
		if (known_codes.size() > 0)
			c = known_codes[$urandom_range(0, known_codes.size() - 1)];
		if (pick < 60 && known_codes.size() > 0) begin
			send_code(c);
		end else if (pick < 78) begin
			repeat ($urandom_range(1, 4))
				queue_item(make_decode(1'($urandom_range(0, 1))));
		end else if (reuse && pick < 89 && known_codes.size() > 0) begin
			// same path again, only the symbol changes
			queue_item(make_insert(8'($urandom), c.code, c.len));
		end else if (pick < 96) begin
			queue_item(make_insert(8'($urandom), 16'($urandom), 5'($urandom_range(1, 9))));
		end else begin
			queue_item(make_insert(8'($urandom), 16'($urandom), 5'($urandom_range(0, 31))));
		end
	endtask

	initial begin : stimulus
		int m;
		int k;
		for (m = 0; m < 2; m++) begin
			for (k = 0; k < NODES; k++) begin
				left_of[m][k] = '0;
				right_of[m][k] = '0;
				sym_at[m][k] = '0;
				sym_set[m][k] = 1'b0;
			end
			free_next[m] = 1;
			walk_at[m] = '0;
		end

		// directed: empty tree, a small code, root symbol, growth while decoding
		queue_item(make_decode(1'b0));
		queue_item(make_insert(8'h00, 16'hFFFE, 5'd1));
		queue_item(make_insert(8'hFF, 16'hAAAA, 5'd2));
		queue_item(make_insert(8'h5A, 16'h0006, 5'd3));
		queue_item(make_insert(8'hA5, 16'hFFFF, 5'd3));
		queue_item(make_insert(8'h3C, 16'h1234, 5'd0));
		queue_item(make_decode(1'b0));
		queue_item(make_decode(1'b1));
		queue_item(make_decode(1'b0));
		queue_item(make_decode(1'b1));
		// leaf "0" turns into an inner node half way through a decode
		queue_item(make_insert(8'h22, 16'h5551, 5'd2));
		queue_item(make_decode(1'b1));
		queue_item(make_decode(1'b1));
		queue_item(make_decode(1'b0));
		queue_item(make_decode(1'b1));
		queue_item(make_decode(1'b0));
		queue_item(make_decode(1'b0));
		// length above the maximum is cut to the maximum
		queue_item(make_insert(8'h77, 16'h7FFF, 5'd31));
		queue_item(make_insert(8'h99, 16'h0002, 5'd2));
		queue_item(make_decode(1'b1));
		queue_item(make_decode(1'b0));

		drain_next = 1'b1;
		while (pending.size() < PART_A_ITEMS)
			random_burst(1'b0);
		// long codes until the node table runs out
		while (planned_full < 3)
			queue_item(make_insert(8'($urandom), 16'($urandom), 5'($urandom_range(16, 31))));
		drain_next = 1'b1;
		while (pending.size() < TOTAL_ITEMS || planned_results < 60)
			random_burst(1'b1);
		item_total = pending.size();

		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		while (pending.size() > 0 || expected_q.size() > 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("decoder run: %0d items, %0d of them inserts, %0d node table entries used",
			items_in, inserts_in, free_next[1]);
		$display("results: %0d symbols, %0d bad paths, %0d table full, %0d errors",
			seen_sym, seen_bad, seen_full, errors);
		if (errors == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

	always @(negedge clk) begin : send_items
		bit offer;
		offer = 1'b0;
		if (arst_n && pending.size() > 0) begin
			if (pending[0].drain_first && expected_q.size() > 0)
				offer = 1'b0;
			else if (tx_gap > 0)
				tx_gap--;
			else if (!no_gaps && $urandom_range(0, 11) == 0)
				tx_gap = $urandom_range(0, 10);
			else
				offer = 1'b1;
		end
		push <= offer;
		if (pending.size() > 0) begin
			opcode <= pending[0].op;
			symbol_byte <= pending[0].sym;
			code_bits <= pending[0].code;
			code_length <= pending[0].len;
			stream_bit <= pending[0].sbit;
		end
	end

	always @(negedge clk) begin : take_results
		bit ready;
		ready = 1'b0;
		if (rx_hold > 0) begin
			rx_hold--;
		end else if (!long_hold_done && items_in >= 300) begin
			// hold off long enough for the block to back up and raise full
			long_hold_done = 1'b1;
			rx_hold = 400;
		end else if (rx_gap > 0) begin
			rx_gap--;
		end else if (!no_gaps && $urandom_range(0, 11) == 0) begin
			rx_gap = $urandom_range(0, 10);
		end else begin
			ready = 1'b1;
		end
		pop <= ready;
	end

	always @(posedge clk) begin : watch_ports
		tree_item_t got;
		outcome_t res;
		outcome_t want;
		bit has;
		bit moved;
		moved = 1'b0;
		if (arst_n) begin
			// results first: an item taken at this edge cannot have produced one yet
			if (pop && !empty) begin
				moved = 1'b1;
				if (status == ST_OK)
					seen_sym++;
				else if (status == ST_BAD_PATH)
					seen_bad++;
				else
					seen_full++;
				if (expected_q.size() == 0) begin
					$display("%0t: result with none expected, status %0d symbol %02h",
						$time, status, decoded_symbol);
					errors++;
				end else begin
					want = expected_q.pop_front();
					if (status !== want.status) begin
						$display("%0t: status expected %0d, got %0d", $time, want.status, status);
						errors++;
					end
					if (decoded_symbol !== want.sym) begin
						$display("%0t: symbol expected %02h, got %02h", $time, want.sym,
							decoded_symbol);
						errors++;
					end
				end
			end
			if (push && !full) begin
				moved = 1'b1;
				got.drain_first = 1'b0;
				got.op = opcode;
				got.sym = symbol_byte;
				got.code = code_bits;
				got.len = code_length;
				got.sbit = stream_bit;
				void'(pending.pop_front());
				tree_apply(1, got, has, res);
				if (has)
					expected_q.push_back(res);
				items_in++;
				if (opcode == OP_INSERT)
					inserts_in++;
			end
			idle_cycles = moved ? 0 : idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("%0t: nothing moved for %0d cycles, %0d items left, %0d results owed",
					$time, idle_cycles, pending.size(), expected_q.size());
				$display("tb_top NOT OK");
				$finish;
			end
		end
	end

endmodule

// ----- sim.f -----
sv/pctd_pkg.sv
sv/pctd_front.sv
sv/pctd_queue.sv
sv/pctd_back.sv
sv/prefix_code_tree_decoder_core.sv
tb/tb_top.sv
